>>> hdl/assert_macros.svh
// assertion macros shared by the ray segment closest hit rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define RSCH_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define RSCH_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define RSCH_ASSERT_IMP(label, ante, cons)

`define RSCH_ASSERT_NXT(label, ante, cons)

`endif

`endif

>>> hdl/rsch_pkg.sv
// shared constants, types and helper functions of the ray segment closest hit core
package rsch_pkg;

    localparam int COORD_WIDTH      = 24;
    localparam int WALL_INDEX_WIDTH = 16;
    localparam int DIFF_W           = COORD_WIDTH + 1;
    localparam int PROD_W           = 2 * DIFF_W + 1;
    localparam int MAC_A_W          = PROD_W;
    localparam int MAC_B_W          = DIFF_W;
    localparam int MAC_P_W          = MAC_A_W + MAC_B_W;
    localparam int MAC_H_W          = MAC_A_W + 2;
    localparam int MAC_CNT_W        = $clog2(MAC_B_W + 1);
    localparam int QUO_W            = DIFF_W;
    localparam int DIV_CNT_W        = $clog2(QUO_W + 1);

    typedef enum logic {
        CMD_BEGIN = 1'b0,
        CMD_WALL  = 1'b1
    } cmd_t;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]      diff_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [MAC_P_W-1:0]     mac_prod_t;
    typedef logic signed [QUO_W-1:0]       quo_t;
    typedef logic [WALL_INDEX_WIDTH-1:0]   widx_t;

    // operands of one serial multiply-difference: a1*b1 - a2*b2
    typedef struct packed {
        prod_t a1;
        prod_t a2;
        diff_t b1;
        diff_t b2;
    } mac_op_t;

    function automatic diff_t sdiff(coord_t a, coord_t b);
        diff_t ea;
        diff_t eb;
        ea = diff_t'(a);
        eb = diff_t'(b);
        return ea - eb;
    endfunction

    // num/den lies in [0,1] without dividing
    function automatic logic in_unit(prod_t num, prod_t den);
        logic ok;
        if (den > 0)
        begin
            ok = (num >= 0) && (num <= den);
        end
        else
        begin
            ok = (num <= 0) && (num >= den);
        end
        return ok;
    endfunction

endpackage

>>> hdl/ray_segment_closest_hit_core.sv
// top level of the ray segment closest hit core: control, ray state and result register
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+--------------------------------------------------
//  in      | in_valid  | in_stall  | command, point_a_x/y, point_b_x/y, last_item
//  out     | out_valid | out_stall | hit_x, hit_y, hit_found, hit_wall
//
//  a begin item goes straight to the finish state; a wall item runs one pass of the
//  bit-serial multipliers, and a taken wall runs a second pass and then the restoring
//  divider (one quotient bit per cycle)
//  rst_n clears the ray, hit and counter state to zero and empties the result register
//  in_stall is high while an item is in process; a stalled result waits in its
//  register and the next item is taken meanwhile; a last item then waits in ST_FINISH
`include "assert_macros.svh"

module ray_segment_closest_hit_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         command,
    input  logic signed [rsch_pkg::COORD_WIDTH-1:0] point_a_x,
    input  logic signed [rsch_pkg::COORD_WIDTH-1:0] point_a_y,
    input  logic signed [rsch_pkg::COORD_WIDTH-1:0] point_b_x,
    input  logic signed [rsch_pkg::COORD_WIDTH-1:0] point_b_y,
    input  logic                         last_item,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [rsch_pkg::COORD_WIDTH-1:0] hit_x,
    output logic signed [rsch_pkg::COORD_WIDTH-1:0] hit_y,
    output logic                         hit_found,
    output logic [rsch_pkg::WALL_INDEX_WIDTH-1:0]   hit_wall
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_TEST,
        ST_MUL2,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    rsch_pkg::coord_t ray_start_x_reg, ray_start_x_next;
    rsch_pkg::coord_t ray_start_y_reg, ray_start_y_next;
    rsch_pkg::coord_t ray_end_x_reg, ray_end_x_next;
    rsch_pkg::coord_t ray_end_y_reg, ray_end_y_next;
    logic             hit_seen_reg, hit_seen_next;
    rsch_pkg::widx_t  hit_idx_reg, hit_idx_next;
    rsch_pkg::widx_t  wall_cnt_reg, wall_cnt_next;
    rsch_pkg::diff_t  wx_reg, wx_next;
    rsch_pkg::diff_t  wy_reg, wy_next;
    rsch_pkg::coord_t ax_reg, ax_next;
    rsch_pkg::coord_t ay_reg, ay_next;
    logic             last_reg, last_next;
    rsch_pkg::prod_t  den_reg, den_next;
    logic             out_valid_reg, out_valid_next;
    rsch_pkg::coord_t hit_x_reg, hit_x_next;
    rsch_pkg::coord_t hit_y_reg, hit_y_next;
    logic             hit_found_reg, hit_found_next;
    rsch_pkg::widx_t  hit_wall_reg, hit_wall_next;

    rsch_pkg::diff_t     wx_in, wy_in, rx, ry, dx, dy;
    rsch_pkg::mac_op_t   mac0_op, mac1_op, mac2_op;
    rsch_pkg::mac_prod_t mac0_product, mac1_product, mac2_product;
    logic                mac0_busy, mac1_busy, mac2_busy;
    logic                mac_start_p1, mac_start_p2, mac_start_xy;
    rsch_pkg::prod_t     den_c, s_num, t_num;
    logic                hit_cond;
    logic                div_start;
    rsch_pkg::quo_t      qx, qy;
    logic                div_x_busy, div_y_busy;
    logic                in_mul;
    logic                begin_accept;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign hit_x     = hit_x_reg;
    assign hit_y     = hit_y_reg;
    assign hit_found = hit_found_reg;
    assign hit_wall  = hit_wall_reg;

    assign in_mul       = (state_reg == ST_MUL1) || (state_reg == ST_MUL2);
    assign begin_accept = in_valid && !in_stall && (command == rsch_pkg::CMD_BEGIN);

    assign wx_in = rsch_pkg::sdiff(point_b_x, point_a_x);
    assign wy_in = rsch_pkg::sdiff(point_b_y, point_a_y);
    assign rx    = rsch_pkg::sdiff(ray_end_x_reg, ray_start_x_reg);
    assign ry    = rsch_pkg::sdiff(ray_end_y_reg, ray_start_y_reg);
    assign dx    = rsch_pkg::sdiff(point_a_x, ray_start_x_reg);
    assign dy    = rsch_pkg::sdiff(point_a_y, ray_start_y_reg);

    assign den_c = rsch_pkg::prod_t'(mac0_product);
    assign s_num = rsch_pkg::prod_t'(mac1_product);
    assign t_num = rsch_pkg::prod_t'(mac2_product);

    assign hit_cond = (den_c != '0) && rsch_pkg::in_unit(s_num, den_c)
                      && rsch_pkg::in_unit(t_num, den_c);

    assign mac_start_xy = mac_start_p1 || mac_start_p2;

    // first pass: den, s and t numerators; second pass: t times the wall vector
    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            mac0_op.a1 = rsch_pkg::prod_t'(wx_in);
            mac0_op.b1 = ry;
            mac0_op.a2 = rsch_pkg::prod_t'(rx);
            mac0_op.b2 = wy_in;
            mac1_op.a1 = rsch_pkg::prod_t'(wx_in);
            mac1_op.b1 = dy;
            mac1_op.a2 = rsch_pkg::prod_t'(wy_in);
            mac1_op.b2 = dx;
        end
        else
        begin
            mac0_op.a1 = t_num;
            mac0_op.b1 = wx_reg;
            mac0_op.a2 = '0;
            mac0_op.b2 = '0;
            mac1_op.a1 = t_num;
            mac1_op.b1 = wy_reg;
            mac1_op.a2 = '0;
            mac1_op.b2 = '0;
        end
        mac2_op.a1 = rsch_pkg::prod_t'(rx);
        mac2_op.b1 = dy;
        mac2_op.a2 = rsch_pkg::prod_t'(ry);
        mac2_op.b2 = dx;
    end

    rsch_mac u_mac0 (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mac_start_xy),
        .op      (mac0_op),
        .product (mac0_product),
        .busy    (mac0_busy)
    );

    rsch_mac u_mac1 (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mac_start_xy),
        .op      (mac1_op),
        .product (mac1_product),
        .busy    (mac1_busy)
    );

    rsch_mac u_mac2 (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mac_start_p1),
        .op      (mac2_op),
        .product (mac2_product),
        .busy    (mac2_busy)
    );

    rsch_div u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mac0_product),
        .divisor  (den_reg),
        .quotient (qx),
        .busy     (div_x_busy)
    );

    rsch_div u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mac1_product),
        .divisor  (den_reg),
        .quotient (qy),
        .busy     (div_y_busy)
    );

    always_comb
    begin
        state_next       = state_reg;
        ray_start_x_next = ray_start_x_reg;
        ray_start_y_next = ray_start_y_reg;
        ray_end_x_next   = ray_end_x_reg;
        ray_end_y_next   = ray_end_y_reg;
        hit_seen_next    = hit_seen_reg;
        hit_idx_next     = hit_idx_reg;
        wall_cnt_next    = wall_cnt_reg;
        wx_next          = wx_reg;
        wy_next          = wy_reg;
        ax_next          = ax_reg;
        ay_next          = ay_reg;
        last_next        = last_reg;
        den_next         = den_reg;
        out_valid_next   = out_valid_reg;
        hit_x_next       = hit_x_reg;
        hit_y_next       = hit_y_reg;
        hit_found_next   = hit_found_reg;
        hit_wall_next    = hit_wall_reg;
        mac_start_p1     = 1'b0;
        mac_start_p2     = 1'b0;
        div_start        = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    last_next = last_item;
                    if (command == rsch_pkg::CMD_BEGIN)
                    begin
                        ray_start_x_next = point_a_x;
                        ray_start_y_next = point_a_y;
                        ray_end_x_next   = point_b_x;
                        ray_end_y_next   = point_b_y;
                        hit_seen_next    = 1'b0;
                        hit_idx_next     = '0;
                        wall_cnt_next    = '0;
                        state_next       = ST_FINISH;
                    end
                    else
                    begin
                        wx_next      = wx_in;
                        wy_next      = wy_in;
                        ax_next      = point_a_x;
                        ay_next      = point_a_y;
                        mac_start_p1 = 1'b1;
                        state_next   = ST_MUL1;
                    end
                end
            end
            ST_MUL1:
            begin
                if (!mac0_busy)
                begin
                    state_next = ST_TEST;
                end
            end
            ST_TEST:
            begin
                den_next = den_c;
                if (hit_cond)
                begin
                    mac_start_p2 = 1'b1;
                    state_next   = ST_MUL2;
                end
                else
                begin
                    wall_cnt_next = wall_cnt_reg + 1'b1;
                    state_next    = ST_FINISH;
                end
            end
            ST_MUL2:
            begin
                if (!mac0_busy)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (!div_x_busy)
                begin
                    ray_end_x_next = ax_reg + rsch_pkg::coord_t'(qx);
                    ray_end_y_next = ay_reg + rsch_pkg::coord_t'(qy);
                    hit_seen_next  = 1'b1;
                    hit_idx_next   = wall_cnt_reg;
                    wall_cnt_next  = wall_cnt_reg + 1'b1;
                    state_next     = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!last_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    hit_x_next     = ray_end_x_reg;
                    hit_y_next     = ray_end_y_reg;
                    hit_found_next = hit_seen_reg;
                    hit_wall_next  = hit_seen_reg ? hit_idx_reg : '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            ray_start_x_reg <= '0;
            ray_start_y_reg <= '0;
            ray_end_x_reg   <= '0;
            ray_end_y_reg   <= '0;
            hit_seen_reg    <= 1'b0;
            hit_idx_reg     <= '0;
            wall_cnt_reg    <= '0;
            wx_reg          <= '0;
            wy_reg          <= '0;
            ax_reg          <= '0;
            ay_reg          <= '0;
            last_reg        <= 1'b0;
            den_reg         <= '0;
            out_valid_reg   <= 1'b0;
            hit_x_reg       <= '0;
            hit_y_reg       <= '0;
            hit_found_reg   <= 1'b0;
            hit_wall_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            ray_start_x_reg <= ray_start_x_next;
            ray_start_y_reg <= ray_start_y_next;
            ray_end_x_reg   <= ray_end_x_next;
            ray_end_y_reg   <= ray_end_y_next;
            hit_seen_reg    <= hit_seen_next;
            hit_idx_reg     <= hit_idx_next;
            wall_cnt_reg    <= wall_cnt_next;
            wx_reg          <= wx_next;
            wy_reg          <= wy_next;
            ax_reg          <= ax_next;
            ay_reg          <= ay_next;
            last_reg        <= last_next;
            den_reg         <= den_next;
            out_valid_reg   <= out_valid_next;
            hit_x_reg       <= hit_x_next;
            hit_y_reg       <= hit_y_next;
            hit_found_reg   <= hit_found_next;
            hit_wall_reg    <= hit_wall_next;
        end
    end

    `RSCH_ASSERT_IMP(a_mac_xy_lockstep, in_mul, mac0_busy == mac1_busy)
    `RSCH_ASSERT_IMP(a_mac_t_lockstep, state_reg == ST_MUL1, mac2_busy == mac0_busy)
    `RSCH_ASSERT_IMP(a_div_lockstep, state_reg == ST_DIV, div_x_busy == div_y_busy)
    `RSCH_ASSERT_IMP(a_div_den_nonzero, div_start, den_reg != '0)
    `RSCH_ASSERT_NXT(a_begin_clears, begin_accept, !hit_seen_reg && wall_cnt_reg == '0)

endmodule

>>> hdl/rsch_mac.sv
// bit-serial signed multiply-difference unit, one multiplier bit per cycle
module rsch_mac (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  rsch_pkg::mac_op_t   op,
    output rsch_pkg::mac_prod_t product,
    output logic                busy
);

    logic signed [rsch_pkg::MAC_A_W-1:0] a1_reg, a1_next;
    logic signed [rsch_pkg::MAC_A_W-1:0] a2_reg, a2_next;
    logic [rsch_pkg::MAC_B_W-1:0]        b1_reg, b1_next;
    logic [rsch_pkg::MAC_B_W-1:0]        b2_reg, b2_next;
    logic signed [rsch_pkg::MAC_H_W-1:0] h_reg, h_next;
    logic [rsch_pkg::MAC_B_W-1:0]        l_reg, l_next;
    logic [rsch_pkg::MAC_CNT_W-1:0]      cnt_reg, cnt_next;

    logic signed [rsch_pkg::MAC_H_W-1:0] t1;
    logic signed [rsch_pkg::MAC_H_W-1:0] t2;
    logic signed [rsch_pkg::MAC_H_W-1:0] sum;
    logic                                last_step;

    assign busy      = (cnt_reg != '0);
    assign last_step = (cnt_reg == rsch_pkg::MAC_CNT_W'(1));
    assign product   = $signed({h_reg[rsch_pkg::MAC_A_W-1:0], l_reg});

    always_comb
    begin
        t1 = b1_reg[0] ? rsch_pkg::MAC_H_W'(a1_reg) : '0;
        t2 = b2_reg[0] ? rsch_pkg::MAC_H_W'(a2_reg) : '0;
        // sign bit of the multiplier carries negative weight
        if (last_step)
        begin
            sum = h_reg - t1 + t2;
        end
        else
        begin
            sum = h_reg + t1 - t2;
        end
    end

    always_comb
    begin
        a1_next  = a1_reg;
        a2_next  = a2_reg;
        b1_next  = b1_reg;
        b2_next  = b2_reg;
        h_next   = h_reg;
        l_next   = l_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            a1_next  = $signed(op.a1);
            a2_next  = $signed(op.a2);
            b1_next  = op.b1;
            b2_next  = op.b2;
            h_next   = '0;
            l_next   = '0;
            cnt_next = rsch_pkg::MAC_CNT_W'(rsch_pkg::MAC_B_W);
        end
        else if (busy)
        begin
            h_next   = sum >>> 1;
            l_next   = {sum[0], l_reg[rsch_pkg::MAC_B_W-1:1]};
            b1_next  = b1_reg >> 1;
            b2_next  = b2_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a1_reg <= a1_next;
        a2_reg <= a2_next;
        b1_reg <= b1_next;
        b2_reg <= b2_next;
        h_reg  <= h_next;
        l_reg  <= l_next;
    end

endmodule

>>> hdl/rsch_div.sv
// restoring signed divider, one quotient bit per cycle, truncates toward zero
`include "assert_macros.svh"

module rsch_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  rsch_pkg::mac_prod_t dividend,
    input  rsch_pkg::prod_t     divisor,
    output rsch_pkg::quo_t      quotient,
    output logic                busy
);

    logic [rsch_pkg::PROD_W-1:0]    rem_reg, rem_next;
    logic [rsch_pkg::QUO_W-1:0]     q_reg, q_next;
    logic [rsch_pkg::PROD_W-1:0]    dmag_reg, dmag_next;
    logic                           neg_reg, neg_next;
    logic [rsch_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;

    logic [rsch_pkg::MAC_P_W-1:0]   pmag;
    logic [rsch_pkg::PROD_W-1:0]    dmag;
    logic [rsch_pkg::PROD_W:0]      trial;
    logic [rsch_pkg::PROD_W:0]      trial_sub;
    logic                           ge;
    logic [rsch_pkg::DIV_CNT_W-1:0] cnt_dec;

    assign busy = (cnt_reg != '0);

    assign pmag = dividend[rsch_pkg::MAC_P_W-1] ? rsch_pkg::MAC_P_W'(-dividend)
                                                 : rsch_pkg::MAC_P_W'(dividend);
    assign dmag = divisor[rsch_pkg::PROD_W-1] ? rsch_pkg::PROD_W'(-divisor)
                                              : rsch_pkg::PROD_W'(divisor);

    assign trial     = {rem_reg, q_reg[rsch_pkg::QUO_W-1]};
    assign trial_sub = trial - {1'b0, dmag_reg};
    assign ge        = (trial >= {1'b0, dmag_reg});
    assign cnt_dec   = cnt_reg - 1'b1;

    assign quotient = neg_reg ? -$signed(q_reg) : $signed(q_reg);

    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        dmag_next = dmag_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            // quotient is known to fit, so the upper part starts below the divisor
            rem_next  = pmag[rsch_pkg::MAC_P_W-1:rsch_pkg::QUO_W];
            q_next    = pmag[rsch_pkg::QUO_W-1:0];
            dmag_next = dmag;
            neg_next  = dividend[rsch_pkg::MAC_P_W-1] ^ divisor[rsch_pkg::PROD_W-1];
            cnt_next  = rsch_pkg::DIV_CNT_W'(rsch_pkg::QUO_W);
        end
        else if (busy)
        begin
            rem_next = ge ? trial_sub[rsch_pkg::PROD_W-1:0] : trial[rsch_pkg::PROD_W-1:0];
            q_next   = {q_reg[rsch_pkg::QUO_W-2:0], ge};
            cnt_next = cnt_dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        dmag_reg <= dmag_next;
        neg_reg  <= neg_next;
    end

    `RSCH_ASSERT_IMP(a_div_start_idle, start, !busy)
    `RSCH_ASSERT_NXT(a_div_count_down, busy && !start, cnt_reg == $past(cnt_dec))
    `RSCH_ASSERT_IMP(a_div_rem_below, busy, rem_reg < dmag_reg)

endmodule
